[hw/rtl/swm3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm3_pkg
// Shared types and defaults for the three-axis sliding-window median filter.
// ----------------------------------------------------------------------------
package swm3_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 13;
    localparam int TAPS_W          = 6;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_INIT,
        SEQ_ISSUE,
        SEQ_DRAIN,
        SEQ_END
    } seq_state_t;

    typedef struct packed {
        logic init;
        logic data_vld;
        logic entry_vld;
        logic pass_end;
        logic final_pass;
    } rank_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/swm3_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm3_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/swm3_rank.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm3_rank
// Per-axis rank unit: radix selection of the lower middle value, bit by bit,
// then one pass for the upper middle value. Gives twice the median.
// ----------------------------------------------------------------------------
module swm3_rank import swm3_pkg::*; #(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int LEN_W = $clog2(RING_DEPTH + 1),
    localparam int BIT_W = $clog2(SAMPLE_BITS)
) (
    input  wire logic                   aclk,
    input  wire rank_ctrl_t             ctrl,
    input  wire logic [BIT_W-1:0]       bit_sel,
    input  wire logic [LEN_W-1:0]       k_lo,
    input  wire logic [LEN_W-1:0]       k_hi,
    input  wire logic [SAMPLE_BITS-1:0] rdata,
    output logic      [SAMPLE_BITS:0]   median2
);

    localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // values are kept with the sign bit flipped so that unsigned order applies
    logic [SAMPLE_BITS-1:0] prefix_reg, prefix_next;
    logic [SAMPLE_BITS-1:0] min_gt_reg, min_gt_next;
    logic [LEN_W-1:0]       rank_reg, rank_next;
    logic [LEN_W-1:0]       count_reg, count_next;

    logic [SAMPLE_BITS-1:0] elem;
    logic [SAMPLE_BITS-1:0] ukey;
    logic                   match;
    logic                   hit0;
    logic                   le;
    logic [SAMPLE_BITS-1:0] v1s;
    logic [SAMPLE_BITS-1:0] v2s;

    always_comb begin
        elem = ctrl.entry_vld ? rdata : '0;
        ukey = elem ^ SIGN_BIT;
        match = 1'b1;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (i > int'(bit_sel) && ukey[i] != prefix_reg[i]) begin
                match = 1'b0;
            end
        end
        hit0 = match & ~ukey[bit_sel];
        le   = (ukey <= prefix_reg);

        prefix_next = prefix_reg;
        min_gt_next = min_gt_reg;
        rank_next   = rank_reg;
        count_next  = count_reg;

        if (ctrl.init) begin
            prefix_next = '0;
            min_gt_next = '1;
            rank_next   = k_lo;
            count_next  = '0;
        end else if (ctrl.data_vld) begin
            if (ctrl.final_pass) begin
                if (le) begin
                    count_next = count_reg + 1'b1;
                end else if (ukey < min_gt_reg) begin
                    min_gt_next = ukey;
                end
            end else if (hit0) begin
                count_next = count_reg + 1'b1;
            end
        end else if (ctrl.pass_end && !ctrl.final_pass) begin
            count_next = '0;
            // not enough values below with this bit clear: the bit is set
            if (rank_reg >= count_reg) begin
                prefix_next[bit_sel] = 1'b1;
                rank_next = rank_reg - count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prefix_reg <= prefix_next;
        min_gt_reg <= min_gt_next;
        rank_reg   <= rank_next;
        count_reg  <= count_next;
    end

    always_comb begin
        v1s = prefix_reg ^ SIGN_BIT;
        v2s = ((count_reg > k_hi) ? prefix_reg : min_gt_reg) ^ SIGN_BIT;
        median2 = {v1s[SAMPLE_BITS-1], v1s} + {v2s[SAMPLE_BITS-1], v2s};
    end

endmodule
`default_nettype wire

[hw/rtl/swm3_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm3_seq
// Sequencer: ring write slot and fill count, window walk addressing and
// pass control for the rank units.
// ----------------------------------------------------------------------------
module swm3_seq import swm3_pkg::*; #(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int ADDR_W = $clog2(RING_DEPTH),
    localparam int LEN_W  = $clog2(RING_DEPTH + 1),
    localparam int BIT_W  = $clog2(SAMPLE_BITS),
    localparam int PASS_W = $clog2(SAMPLE_BITS + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TAPS_W-1:0] taps,
    output logic      [ADDR_W-1:0] wr_addr,
    output logic      [ADDR_W-1:0] rd_addr,
    output rank_ctrl_t             ctrl,
    output logic      [BIT_W-1:0]  bit_sel,
    output logic      [LEN_W-1:0]  k_lo,
    output logic      [LEN_W-1:0]  k_hi,
    output logic                   idle,
    output logic                   done
);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] write_slot_reg, write_slot_next;
    logic [ADDR_W-1:0] cur_slot_reg, cur_slot_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              data_vld_reg, data_vld_next;
    logic              entry_vld_reg, entry_vld_next;

    logic [TAPS_W:0]   tap_len;
    logic [LEN_W-1:0]  len_in;
    logic [LEN_W:0]    slot_ext;
    logic [LEN_W:0]    idx_ext;
    logic [LEN_W:0]    rd_full;
    logic              final_pass;

    always_comb begin
        tap_len = {1'b0, taps} + 1'b1;
        len_in  = (int'(tap_len) > RING_DEPTH) ? LEN_W'(RING_DEPTH) : LEN_W'(tap_len);

        // walk backward from the newest entry
        slot_ext = (LEN_W+1)'(cur_slot_reg);
        idx_ext  = (LEN_W+1)'(idx_reg);
        rd_full  = (slot_ext >= idx_ext) ? slot_ext - idx_ext
                                         : slot_ext + (LEN_W+1)'(RING_DEPTH) - idx_ext;
        rd_addr  = rd_full[ADDR_W-1:0];

        final_pass = (pass_reg == PASS_W'(SAMPLE_BITS));

        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        cur_slot_next   = cur_slot_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        done            = 1'b0;

        unique case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    state_next    = SEQ_INIT;
                    len_next      = len_in;
                    cur_slot_next = write_slot_reg;
                    write_slot_next = (write_slot_reg == ADDR_W'(RING_DEPTH - 1))
                                      ? '0 : write_slot_reg + 1'b1;
                    if (fill_reg != LEN_W'(RING_DEPTH)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            SEQ_INIT: begin
                idx_next   = '0;
                pass_next  = '0;
                state_next = SEQ_ISSUE;
            end
            SEQ_ISSUE: begin
                if (idx_reg == len_reg - 1'b1) begin
                    state_next = SEQ_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            SEQ_DRAIN: begin
                state_next = SEQ_END;
            end
            SEQ_END: begin
                idx_next = '0;
                if (final_pass) begin
                    done       = 1'b1;
                    state_next = SEQ_IDLE;
                end else begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = SEQ_ISSUE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase

        data_vld_next  = (state_reg == SEQ_ISSUE);
        // slots never written since reset read as zero
        entry_vld_next = (rd_full < (LEN_W+1)'(fill_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_IDLE;
            write_slot_reg <= '0;
            fill_reg       <= '0;
            data_vld_reg   <= 1'b0;
            entry_vld_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            fill_reg       <= fill_next;
            data_vld_reg   <= data_vld_next;
            entry_vld_reg  <= entry_vld_next;
        end
        cur_slot_reg <= cur_slot_next;
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        pass_reg     <= pass_next;
    end

    always_comb begin
        ctrl.init       = (state_reg == SEQ_INIT);
        ctrl.data_vld   = data_vld_reg;
        ctrl.entry_vld  = entry_vld_reg;
        ctrl.pass_end   = (state_reg == SEQ_END);
        ctrl.final_pass = final_pass;
        bit_sel = BIT_W'(SAMPLE_BITS - 1 - int'(pass_reg));
        k_lo    = (len_reg - 1'b1) >> 1;
        k_hi    = len_reg >> 1;
        idle    = (state_reg == SEQ_IDLE);
        wr_addr = write_slot_reg;
    end

endmodule
`default_nettype wire

[hw/rtl/sliding_window_median_3axis.sv]
`timescale 1ns / 1ps
`default_nettype none
// pass-through (window_taps zero) gives the item in the cycle after accept; otherwise the
//   sample is written to the ring and the sequencer runs INIT, then SAMPLE_BITS + 1 passes,
//   each of ISSUE over len = min(window_taps + 1, RING_DEPTH) entries, DRAIN and END
// throughput: pass-through one item per cycle while the output is free; otherwise input is
//   not ready during the window walks over each ring's single read port and while a result waits
// reset: window_taps, write slot and fill count go to zero; unwritten slots read as zero
// ----------------------------------------------------------------------------
// sliding_window_median_3axis
// Running median over a configurable window for a three-axis sample stream.
// ----------------------------------------------------------------------------
module sliding_window_median_3axis import swm3_pkg::*; #(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_W   = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((3 * (SAMPLE_BITS + 1) + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [TAPS_W-1:0] cfg_wr_data,   // window_taps
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,  // mag_x, mag_y, mag_z, zero pad
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OUT_W-1:0]  m_axis_tdata   // median2_x, median2_y, median2_z, pad
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int LEN_W  = $clog2(RING_DEPTH + 1);
    localparam int BIT_W  = $clog2(SAMPLE_BITS);

    logic [TAPS_W-1:0] taps_reg, taps_next;
    logic              pending_reg, pending_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    logic              accept;
    logic              pass_thru;
    logic              out_free;
    logic              start;
    logic              out_load_med;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    rank_ctrl_t        ctrl;
    logic [BIT_W-1:0]  bit_sel;
    logic [LEN_W-1:0]  k_lo;
    logic [LEN_W-1:0]  k_hi;
    logic              seq_idle;
    logic              seq_done;

    logic [SAMPLE_BITS-1:0] samp    [3];
    logic [SAMPLE_BITS-1:0] rdata   [3];
    logic [SAMPLE_BITS:0]   median2 [3];

    swm3_seq #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .taps    (taps_reg),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .ctrl    (ctrl),
        .bit_sel (bit_sel),
        .k_lo    (k_lo),
        .k_hi    (k_hi),
        .idle    (seq_idle),
        .done    (seq_done)
    );

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign samp[a] = s_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS];

        swm3_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (RING_DEPTH)
        ) u_ring (
            .aclk  (aclk),
            .we    (start),
            .waddr (wr_addr),
            .wdata (samp[a]),
            .raddr (rd_addr),
            .rdata (rdata[a])
        );

        swm3_rank #(
            .RING_DEPTH  (RING_DEPTH),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_rank (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .bit_sel (bit_sel),
            .k_lo    (k_lo),
            .k_hi    (k_hi),
            .rdata   (rdata[a]),
            .median2 (median2[a])
        );
    end

    always_comb begin
        pass_thru     = (taps_reg == '0);
        out_free      = !m_tvalid_reg || m_axis_tready;
        s_axis_tready = seq_idle && !pending_reg && (!pass_thru || out_free);
        accept        = s_axis_tvalid && s_axis_tready;
        start         = accept && !pass_thru;
        out_load_med  = pending_reg && out_free;

        taps_next     = cfg_wr_en ? cfg_wr_data : taps_reg;

        pending_next = pending_reg;
        if (seq_done) begin
            pending_next = 1'b1;
        end else if (out_load_med) begin
            pending_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept && pass_thru) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({samp[2], 1'b0, samp[1], 1'b0, samp[0], 1'b0});
        end else if (out_load_med) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({median2[2], median2[1], median2[0]});
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg     <= '0;
            pending_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            taps_reg     <= taps_next;
            pending_reg  <= pending_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // a finished median never lands on a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_done |-> !pending_reg)
        else $error("median finished while previous result pending");

    // no item taken while the window walk runs
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !seq_idle |-> !s_axis_tready)
        else $error("input ready during window walk");

    // pass-through item shows up on the next cycle
    a_pass_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pass_thru) |=> m_axis_tvalid)
        else $error("pass-through item not presented");

endmodule
`default_nettype wire

[tb/sliding_window_median_3axis_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_3axis_tb
// Streams three-axis samples through the running median filter over a range of
// window lengths, predicts every doubled median with an independent window
// model and compares each result item field by field, under random sender
// bursts and receiver stalls.
// ----------------------------------------------------------------------------
module sliding_window_median_3axis_tb;
    import swm3_pkg::*;

    localparam int RING     = RING_DEPTH_DEF;
    localparam int SAMPLE_W = SAMPLE_BITS_DEF;
    localparam int MED_W    = SAMPLE_W + 1;
    localparam int IN_W     = ((3 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W    = ((3 * MED_W + 7) / 8) * 8;
    localparam int SMP_MIN  = -(1 << (SAMPLE_W - 1));
    localparam int SMP_MAX  = (1 << (SAMPLE_W - 1)) - 1;
    localparam int MAX_TAPS = (1 << TAPS_W) - 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MED_W-1:0]    median2_t;
    typedef struct packed {
        median2_t z;
        median2_t y;
        median2_t x;
    } medians_t;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_TRICKLE} rx_mode_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             cfg_en   = 1'b0;
    logic [TAPS_W-1:0] cfg_data = '0;
    logic             s_valid  = 1'b0;
    logic [IN_W-1:0]  s_data   = '0;
    logic             m_ready  = 1'b0;
    wire              s_ready;
    wire              m_valid;
    wire [OUT_W-1:0]  m_data;

    sliding_window_median_3axis u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_en),
        .cfg_wr_data   (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // mag_x, mag_y, mag_z, zero pad
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)     // median2_x, median2_y, median2_z, pad
    );

    // window model state
    int       history [3][RING];
    int       next_slot;
    int       taps_model;
    medians_t pending_medians[$];
    int       errors;

    // stimulus state
    int       burst_left;
    int       cluster_base [3];
    int       last_axis [3];
    int       items_sent;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("sliding_window_median_3axis verification failed");
        $finish;
    end

    function automatic int window_median2(int axis, int len);
        int sorted [RING];
        int v;
        int j;
        for (int i = 0; i < len; i++) begin
            v = history[axis][(next_slot + RING - (len - 1 - i)) % RING];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (len % 2 == 1) begin
            return 2 * sorted[len / 2];
        end
        return sorted[len / 2 - 1] + sorted[len / 2];
    endfunction

    function automatic medians_t predict_medians(int x, int y, int z);
        medians_t r;
        int smp [3];
        int m [3];
        int len;
        smp[0] = x;
        smp[1] = y;
        smp[2] = z;
        len = taps_model + 1;
        if (len < 2) begin
            for (int a = 0; a < 3; a++) m[a] = 2 * smp[a];
        end else begin
            if (len > RING) len = RING;
            for (int a = 0; a < 3; a++) history[a][next_slot] = smp[a];
            for (int a = 0; a < 3; a++) m[a] = window_median2(a, len);
            next_slot = (next_slot + 1) % RING;
        end
        r.x = median2_t'(m[0]);
        r.y = median2_t'(m[1]);
        r.z = median2_t'(m[2]);
        return r;
    endfunction

    function automatic int draw_axis(int a);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'(sample_t'($urandom_range(0, (1 << SAMPLE_W) - 1)));
            4, 5: begin
                case ($urandom_range(0, 3))
                    0: v = SMP_MIN;
                    1: v = SMP_MAX;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            6, 7, 8: begin
                v = cluster_base[a] + $urandom_range(0, 64) - 32;
                if (v < SMP_MIN) v = SMP_MIN;
                if (v > SMP_MAX) v = SMP_MAX;
            end
            default: v = last_axis[a];    // repeats make ties in the sort
        endcase
        last_axis[a] = v;
        return v;
    endfunction

    // one item: a burst gap when the burst runs out, then hold until accepted
    task automatic send_sample(input int x, input int y, input int z);
        int pause;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 7))
                0, 1:    pause = 0;
                2, 3, 4: pause = $urandom_range(1, 8);
                5, 6:    pause = $urandom_range(9, 60);
                default: pause = $urandom_range(61, 300);
            endcase
            if (pause > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                s_data  <= IN_W'({$urandom, $urandom});
                repeat (pause - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= {{(IN_W - 3 * SAMPLE_W){1'b0}}, sample_t'(z), sample_t'(y), sample_t'(x)};
        do @(posedge aclk); while (!s_ready);
        pending_medians.push_back(predict_medians(x, y, z));
        items_sent++;
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_sample(draw_axis(0), draw_axis(1), draw_axis(2));
        end
    endtask

    // drop valid right after the last accept, then drain the result queue
    task automatic drain_phase();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
    endtask

    task automatic set_window_taps(input int taps);
        @(negedge aclk);
        cfg_en   <= 1'b1;
        cfg_data <= TAPS_W'(taps);
        @(posedge aclk);
        taps_model = taps;
        @(negedge aclk);
        cfg_en <= 1'b0;
    endtask

    task automatic test_pass_through();
        send_sample(SMP_MIN, SMP_MAX, 0);
        send_sample(SMP_MAX, SMP_MIN, -1);
        send_sample(-1, 0, SMP_MIN);
        drain_phase();
    endtask

    // ring is still all zeros, so these windows mix zeros with samples
    task automatic test_early_windows();
        set_window_taps(3);
        send_sample(SMP_MAX, SMP_MIN, -1);
        send_sample(SMP_MIN, SMP_MAX, 1);
        send_sample(-1, SMP_MIN, SMP_MAX);
        send_sample(0, 1, -1);
        drain_phase();
    endtask

    task automatic test_window_parity();
        set_window_taps(1);
        send_sample(SMP_MIN, SMP_MAX, SMP_MAX);
        send_sample(SMP_MIN, SMP_MIN, SMP_MAX);
        drain_phase();
        set_window_taps(2);
        send_sample(SMP_MAX, -1, 0);
        send_sample(SMP_MAX, SMP_MIN, 0);
        drain_phase();
    endtask

    task automatic test_full_ring_early();
        set_window_taps(MAX_TAPS);
        send_sample(SMP_MAX, SMP_MAX, SMP_MIN);
        send_sample(SMP_MIN, SMP_MAX, SMP_MIN);
        send_sample(-1, SMP_MAX, 5);
        drain_phase();
    endtask

    // pass-through must leave the ring and write slot alone
    task automatic test_pass_through_keeps_ring();
        set_window_taps(0);
        send_sample(1234, -1234, SMP_MIN);
        send_sample(SMP_MAX, 77, -77);
        drain_phase();
        set_window_taps(3);
        send_sample(10, -10, 0);
        drain_phase();
    endtask

    task automatic test_random_windows();
        int taps;
        int count;
        while (items_sent < 850) begin
            case ($urandom_range(0, 19))
                0, 1:                       taps = 0;
                2, 3, 4, 5, 6, 7, 8, 9, 10, 11: taps = $urandom_range(1, 4);
                12, 13, 14, 15, 16:         taps = $urandom_range(5, 12);
                17, 18:                     taps = $urandom_range(13, 31);
                default:                    taps = $urandom_range(MAX_TAPS - 1, MAX_TAPS);
            endcase
            count = (taps > 31) ? $urandom_range(5, 15) : $urandom_range(20, 60);
            for (int a = 0; a < 3; a++) cluster_base[a] = draw_axis(a);
            set_window_taps(taps);
            send_random(count);
            drain_phase();
        end
    endtask

    task automatic test_widest_window();
        set_window_taps(MAX_TAPS);
        send_random(45);
        drain_phase();
    endtask

    // receiver stall pattern that switches between random modes
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_HALF:   m_ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic void compare_axis(string field, median2_t want, median2_t got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        medians_t got;
        medians_t want;
        if (aresetn && m_valid && m_ready) begin
            got = medians_t'(m_data[3*MED_W-1:0]);
            if (pending_medians.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none actual %h", $time, got);
            end else begin
                want = pending_medians.pop_front();
                compare_axis("median2_x", want.x, got.x);
                compare_axis("median2_y", want.y, got.y);
                compare_axis("median2_z", want.z, got.z);
            end
        end
    end

    initial begin
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < RING; i++) history[a][i] = 0;
            cluster_base[a] = 0;
            last_axis[a]    = 0;
        end
        next_slot  = 0;
        taps_model = 0;
        errors     = 0;
        burst_left = 0;
        items_sent = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_pass_through();
        test_early_windows();
        test_window_parity();
        test_full_ring_early();
        test_pass_through_keeps_ring();
        test_random_windows();
        test_widest_window();

        repeat (1000) @(posedge aclk);
        if (errors == 0) begin
            $display("sliding_window_median_3axis verification clean");
        end else begin
            $display("sliding_window_median_3axis verification failed");
        end
        $finish;
    end

endmodule
